### rtl/pip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pip_pkg: shared types and helpers for the point-in-polygon crossing test
// Coordinate widths, per-edge stage records and the edge setup function.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int COORD_BITS = 32;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int CNT_W      = 16;
	localparam int S_DATA_W   = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int M_DATA_W   = ((1 + CNT_W + 7) / 8) * 8;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// op codes carried in s_tuser
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_VERTEX = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	// edge after setup: gating flag, direction flag and the four cross-product operands
	typedef struct packed {
		logic  ok;
		logic  dy_pos;
		diff_t ax_d;   // ax - px
		diff_t dy;     // by - ay
		diff_t ay_d;   // ay - py
		diff_t dx;     // bx - ax
	} edge_s2_t;

	// edge after the multipliers
	typedef struct packed {
		logic  ok;
		logic  dy_pos;
		prod_t p1;     // (ax - px) * dy
		prod_t p2;     // (ay - py) * dx
	} edge_s3_t;

	// Cheap tests of edge A->B against the ray from P: endpoint on P,
	// horizontal edge, P.y outside the closed y span. Also forms operands.
	function automatic edge_s2_t edge_prep(
		input logic   en,
		input coord_t ax,
		input coord_t ay,
		input coord_t bx,
		input coord_t by,
		input coord_t px,
		input coord_t py
	);
		edge_s2_t e;
		logic     hit_pt;
		logic     in_rng;
		hit_pt = ((ax == px) && (ay == py)) || ((bx == px) && (by == py));
		if (ay < by) begin
			in_rng = (py >= ay) && (py <= by);
		end else begin
			in_rng = (py >= by) && (py <= ay);
		end
		e.ok     = en && !hit_pt && (ay != by) && in_rng;
		e.dy_pos = (by > ay);
		e.ax_d   = diff_t'(ax) - diff_t'(px);
		e.dy     = diff_t'(by) - diff_t'(ay);
		e.ay_d   = diff_t'(ay) - diff_t'(py);
		e.dx     = diff_t'(bx) - diff_t'(ax);
		return e;
	endfunction

endpackage
`default_nettype wire

### rtl/point_in_polygon_crossing_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test: streamed ray-casting inside test
// Takes a test point, then the vertices of a closed ring, and reports the
// crossing count of a rightward ray from the point and its parity.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_*): one request per point or vertex. s_tuser = 0 loads
//   the test point and clears the ring; s_tuser = 1 is a ring vertex, and
//   s_tlast on a vertex closes the ring (closing edge last -> first).
//   s_tdata = {coord_y, coord_x}, two's complement.
//   Output stream (m_*): one request per closed ring, m_tdata[0] = inside,
//   m_tdata[16:1] = crossing count saturating at 65535.
// Throughput: one request per clock while the output is not stalled. Both
//   edges of a vertex (previous->current and, on tlast, current->first) are
//   tested in parallel, so the closing vertex is handled like any other vertex.
// Result path: the closing vertex passes the input register, setup, multiply
//   and compare/accumulate stages before the result register.
// Pipeline: s1 input register and ring state, s2 edge setup, s3 products
//   (four 33x33 multipliers), then compare, count and result register.
// Reset: all valids drop, test point and ring vertices go to zero, count
//   clears. The test point survives a result; only a load replaces it.
// Stall: the result register holds while m_tready is low; requests keep
//   flowing until a ring-closing request reaches the last stage, then the
//   pipeline backs up and s_tready falls.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [pip_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] coord_x, [63:32] coord_y
	input  wire                          s_tlast,   // closes the ring
	input  wire                          s_tuser,   // [0] op: 0 load point, 1 vertex
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [pip_pkg::M_DATA_W-1:0] m_tdata    // [0] inside_res, [16:1] crossing_count
);
	import pip_pkg::*;

	// ---- stage 1: input register ----
	logic   v_s1;
	logic   op_s1;
	logic   last_s1;
	coord_t x_s1;
	coord_t y_s1;

	// ring state, updated as a request leaves stage 1
	coord_t pt_x_q, pt_y_q;
	coord_t first_x_q, first_y_q;
	coord_t prev_x_q, prev_y_q;
	logic   have_first_q;

	// ---- stage 2: edge setup ----
	logic     v_s2;
	logic     op_s2;
	logic     last_s2;
	edge_s2_t e0_s2;   // previous -> current
	edge_s2_t e1_s2;   // current -> first (closing edge)

	// ---- stage 3: products ----
	logic     v_s3;
	logic     op_s3;
	logic     last_s3;
	edge_s3_t e0_s3;
	edge_s3_t e1_s3;

	cnt_t crossings_q;
	logic m_tvalid_q;
	cnt_t res_cnt_q;

	// ---- flow control ----
	logic out_ready;
	logic s3_prod;
	logic rdy_s3, rdy_s2, rdy_s1;
	logic adv_s1, adv_s3;

	assign out_ready = !m_tvalid_q || m_tready;
	assign s3_prod   = v_s3 && (op_s3 == OP_VERTEX) && last_s3;
	assign rdy_s3    = !v_s3 || !s3_prod || out_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign adv_s1    = v_s1 && rdy_s2;
	assign adv_s3    = v_s3 && rdy_s3;
	assign s_tready  = rdy_s1;

	// ---- stage 1 combinational: edge setup ----
	logic     is_vtx_s1;
	coord_t   cl_x, cl_y;
	edge_s2_t e0_c, e1_c;

	assign is_vtx_s1 = (op_s1 == OP_VERTEX);
	// single-vertex ring closes onto itself and degenerates
	assign cl_x      = have_first_q ? first_x_q : x_s1;
	assign cl_y      = have_first_q ? first_y_q : y_s1;

	always_comb begin
		e0_c = edge_prep(is_vtx_s1 && have_first_q, prev_x_q, prev_y_q, x_s1, y_s1,
			pt_x_q, pt_y_q);
		e1_c = edge_prep(is_vtx_s1 && last_s1, x_s1, y_s1, cl_x, cl_y,
			pt_x_q, pt_y_q);
	end

	// ---- stage 3 combinational: sign test and saturating count ----
	logic          cross0, cross1;
	logic [CNT_W:0] sum;
	cnt_t          cnt_next;

	always_comb begin
		cross0 = e0_s3.ok && ((e0_s3.p1 == e0_s3.p2) ||
			(($signed(e0_s3.p1) > $signed(e0_s3.p2)) == e0_s3.dy_pos));
		cross1 = e1_s3.ok && ((e1_s3.p1 == e1_s3.p2) ||
			(($signed(e1_s3.p1) > $signed(e1_s3.p2)) == e1_s3.dy_pos));
		sum = {1'b0, crossings_q} + {{CNT_W{1'b0}}, cross0} + {{CNT_W{1'b0}}, cross1};
		if (sum > {1'b0, CNT_MAX}) begin
			cnt_next = CNT_MAX;
		end else begin
			cnt_next = sum[CNT_W-1:0];
		end
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			m_tvalid_q   <= 1'b0;
			have_first_q <= 1'b0;
			crossings_q  <= '0;
			pt_x_q       <= '0;
			pt_y_q       <= '0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (out_ready) m_tvalid_q <= s3_prod;

			if (adv_s1) begin
				if (op_s1 == OP_LOAD) begin
					pt_x_q       <= x_s1;
					pt_y_q       <= y_s1;
					have_first_q <= 1'b0;
				end else begin
					if (!have_first_q) begin
						first_x_q <= x_s1;
						first_y_q <= y_s1;
					end
					prev_x_q     <= x_s1;
					prev_y_q     <= y_s1;
					have_first_q <= !last_s1;
				end
			end

			if (adv_s3) begin
				if (op_s3 == OP_LOAD || last_s3) begin
					crossings_q <= '0;
				end else begin
					crossings_q <= cnt_next;
				end
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			op_s1   <= s_tuser;
			last_s1 <= s_tlast;
			x_s1    <= coord_t'(s_tdata[COORD_BITS-1:0]);
			y_s1    <= coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
		end
		if (rdy_s2) begin
			op_s2   <= op_s1;
			last_s2 <= last_s1;
			e0_s2   <= e0_c;
			e1_s2   <= e1_c;
		end
		if (rdy_s3) begin
			op_s3        <= op_s2;
			last_s3      <= last_s2;
			e0_s3.ok     <= e0_s2.ok;
			e0_s3.dy_pos <= e0_s2.dy_pos;
			e0_s3.p1     <= $signed(e0_s2.ax_d) * $signed(e0_s2.dy);
			e0_s3.p2     <= $signed(e0_s2.ay_d) * $signed(e0_s2.dx);
			e1_s3.ok     <= e1_s2.ok;
			e1_s3.dy_pos <= e1_s2.dy_pos;
			e1_s3.p1     <= $signed(e1_s2.ax_d) * $signed(e1_s2.dy);
			e1_s3.p2     <= $signed(e1_s2.ay_d) * $signed(e1_s2.dx);
		end
		if (out_ready && s3_prod) begin
			res_cnt_q <= cnt_next;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_W-CNT_W-1){1'b0}}, res_cnt_q, res_cnt_q[0]};

	// ---- assertions ----
	a_load_clears_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && op_s1 == OP_LOAD) |=> !have_first_q)
		else $error("ring not cleared by point load");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s3_prod))
		else $error("result without a closing vertex");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && s3_prod) |=> (crossings_q == '0))
		else $error("crossing count kept after result");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && m_tvalid_q))
		else $error("input stalled with a bubble in the pipeline");

endmodule
`default_nettype wire

### tb/sv/tb_point_in_polygon_crossing_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_crossing_test: self-checking bench for the ray test
// Streams test points and polygon rings into the block and predicts every
// ring result with exact wide cross products. It covers the coordinate
// extremes, degenerate edges, broken rings and output back-pressure.
// ----------------------------------------------------------------------------

// Scoreboard: shadow copy of the ring state plus the counts still owed.
class crossing_scoreboard;
	pip_pkg::coord_t pt_x, pt_y;
	pip_pkg::coord_t first_x, first_y;
	pip_pkg::coord_t prev_x, prev_y;
	bit              ring_open;
	pip_pkg::cnt_t   tally;
	pip_pkg::cnt_t   owed_counts[$];
	int              mismatches;

	function new();
		pt_x = 0; pt_y = 0;
		first_x = 0; first_y = 0;
		prev_x = 0; prev_y = 0;
		ring_open = 0;
		tally = 0;
		mismatches = 0;
	endfunction

	// edge A->B against the rightward ray from the test point, exact math
	function bit ray_hits(pip_pkg::coord_t ax, pip_pkg::coord_t ay,
		pip_pkg::coord_t bx, pip_pkg::coord_t by);
		logic signed [127:0] wax, way, wbx, wby, wpx, wpy, dx, dy, num;
		if ((ax == pt_x && ay == pt_y) || (bx == pt_x && by == pt_y))
			return 0;
		wax = ax; way = ay; wbx = bx; wby = by; wpx = pt_x; wpy = pt_y;
		dy = wby - way;
		dx = wbx - wax;
		if (dy == 0)
			return 0;
		if (dy > 0) begin
			if (wpy < way || wpy > wby)
				return 0;
		end else begin
			if (wpy < wby || wpy > way)
				return 0;
		end
		num = (wax - wpx) * dy - (way - wpy) * dx;
		if (num == 0)
			return 1;
		return (num > 0) == (dy > 0);
	endfunction

	function void add_edge(pip_pkg::coord_t ax, pip_pkg::coord_t ay,
		pip_pkg::coord_t bx, pip_pkg::coord_t by);
		if (ray_hits(ax, ay, bx, by) && tally != pip_pkg::CNT_MAX)
			tally = tally + 1'b1;
	endfunction

	// called for every accepted input request
	function void take_request(logic op, pip_pkg::coord_t x, pip_pkg::coord_t y,
		logic last);
		if (op == pip_pkg::OP_LOAD) begin
			pt_x = x; pt_y = y;
			ring_open = 0;
			tally = 0;
			return;
		end
		if (!ring_open) begin
			first_x = x; first_y = y;
			ring_open = 1;
		end else begin
			add_edge(prev_x, prev_y, x, y);
		end
		prev_x = x; prev_y = y;
		if (!last)
			return;
		add_edge(x, y, first_x, first_y);
		owed_counts.insert(owed_counts.size(), tally);
		ring_open = 0;
		tally = 0;
	endfunction

	function void flag(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR %0t: %s", $time, msg);
	endfunction

	// called for every accepted output request
	function void check_result(logic in_bit, logic [pip_pkg::CNT_W-1:0] count);
		pip_pkg::cnt_t want;
		if (owed_counts.size() == 0) begin
			flag($sformatf("unexpected result inside=%b count=%0d", in_bit, count));
			return;
		end
		want = owed_counts.pop_front();
		if (in_bit !== want[0])
			flag($sformatf("inside expected %b got %b", want[0], in_bit));
		if (count !== want)
			flag($sformatf("count expected %0d got %0d", want, count));
	endfunction

	function int pending();
		return owed_counts.size();
	endfunction
endclass

module tb_point_in_polygon_crossing_test;
	import pip_pkg::*;

	localparam int     CYCLE_LIMIT = 1_000_000;
	localparam int     HOLD_CYCLES = 300;     // long receiver hold-off
	localparam int     RAND_ITEMS  = 650;
	localparam coord_t CMIN        = 32'sh8000_0000;
	localparam coord_t CMAX        = 32'sh7fff_ffff;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                s_tlast  = 1'b0;
	logic                s_tuser  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	crossing_scoreboard sb = new();

	int cycle_count = 0;
	int items_sent  = 0;
	bit quiet       = 0;   // no gaps on either side while set
	bit hold_request = 0;  // main asks the receiver for a long hold-off
	bit hold_active  = 0;  // receiver is inside that hold-off

	point_in_polygon_crossing_test uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Gap length: mostly none, some short, a few long. Nothing while quiet.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Coordinate source. 0: small box around the origin, so endpoints hit the
	// point, edges go horizontal and the point lands on edges. 1: full range.
	// 2: extremes and values around zero. 3: any of these per coordinate.
	function automatic coord_t rand_coord(int mode);
		int m;
		m = (mode == 3) ? $urandom_range(0, 2) : mode;
		case (m)
			0: return coord_t'(int'($urandom_range(0, 16)) - 8);
			1: return coord_t'($urandom);
			default: begin
				case ($urandom_range(0, 4))
					0: return CMIN;
					1: return CMAX;
					2: return coord_t'(-1);
					3: return coord_t'(1);
					default: return coord_t'(0);
				endcase
			end
		endcase
	endfunction

	// One input request; valid stays high into the next request when no gap
	// follows, so it never drops and rises in the same step.
	task automatic send_request(logic op, coord_t x, coord_t y, logic last);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tlast  <= last;
		s_tdata  <= {y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.take_request(op, x, y, last);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// n vertices; close marks the final one, clear leaves the ring open
	task automatic send_ring(int n, int mode, bit close);
		for (int i = 0; i < n; i++)
			send_request(OP_VERTEX, rand_coord(mode), rand_coord(mode),
				close && (i == n - 1));
	endtask

	function automatic int ring_size();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(9, 24);
		return $urandom_range(1, 8);
	endfunction

	// Receiver: random ready pattern, full speed when quiet, and the long
	// hold-off on request so the pipeline backs up into s_tready.
	initial begin : ready_driver
		int hi_run;
		int lo_run;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_active = 1;
				m_tready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
				hold_request = 0;
				hold_active  = 0;
			end else if (quiet) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				hi_run = $urandom_range(1, 8);
				lo_run = pick_gap();
				m_tready <= 1'b1;
				repeat (hi_run) @(posedge clk);
				if (lo_run > 0) begin
					m_tready <= 1'b0;
					repeat (lo_run) @(posedge clk);
				end
			end
		end
	end

	// Result monitor: handshake seen at the edge, before any update lands
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[0], m_tdata[CNT_W:1]);
	end

	initial begin : stimulus
		int pick;
		int mode;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// -- directed --
		// vertices before any load use the reset point (0, 0)
		send_request(OP_VERTEX, 4, -4, 1'b0);
		send_request(OP_VERTEX, 4, 4, 1'b0);
		send_request(OP_VERTEX, -4, 0, 1'b1);
		// load with last set is still just a load; then a single-vertex ring
		send_request(OP_LOAD, 1, 1, 1'b1);
		send_request(OP_VERTEX, 5, 5, 1'b1);
		// square at the corners of the coordinate range
		send_request(OP_LOAD, 0, 0, 1'b0);
		send_request(OP_VERTEX, CMAX, CMIN, 1'b0);
		send_request(OP_VERTEX, CMAX, CMAX, 1'b0);
		send_request(OP_VERTEX, CMIN, CMAX, 1'b0);
		send_request(OP_VERTEX, CMIN, CMIN, 1'b1);
		// widest differences: point at one corner, edge at the far side
		send_request(OP_LOAD, CMIN, CMAX, 1'b0);
		send_request(OP_VERTEX, CMAX, CMIN, 1'b0);
		send_request(OP_VERTEX, CMAX, CMAX, 1'b1);
		// a vertex sitting on the test point
		send_request(OP_LOAD, 2, 2, 1'b0);
		send_request(OP_VERTEX, 2, 2, 1'b0);
		send_request(OP_VERTEX, 6, 0, 1'b0);
		send_request(OP_VERTEX, 6, 6, 1'b1);
		// same point kept; horizontal edge on the ray's line
		send_request(OP_VERTEX, -5, 2, 1'b0);
		send_request(OP_VERTEX, 5, 2, 1'b0);
		send_request(OP_VERTEX, 5, 4, 1'b1);
		// point on the interior of an edge (zero cross product)
		send_request(OP_LOAD, 0, 0, 1'b0);
		send_request(OP_VERTEX, -3, -3, 1'b0);
		send_request(OP_VERTEX, 3, 3, 1'b0);
		send_request(OP_VERTEX, 3, -3, 1'b1);

		// -- back-pressure: receiver holds off while rings keep coming --
		quiet = 1;
		hold_request = 1;
		wait (hold_active);
		send_request(OP_LOAD, 0, 0, 1'b0);
		for (int i = 0; i < 40; i++)
			send_ring(3, 0, 1);
		quiet = 0;

		// -- random: mostly well-formed rings, some noise and broken rings --
		while (items_sent < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			mode = $urandom_range(0, 9);
			mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
			if (pick < 6) begin
				send_request(OP_LOAD, rand_coord(mode), rand_coord(mode),
					1'($urandom_range(0, 1)));
			end else if (pick < 18) begin
				// ring cut short by a new load
				send_ring(ring_size(), mode, 0);
				send_request(OP_LOAD, rand_coord(mode), rand_coord(mode),
					1'($urandom_range(0, 1)));
			end else begin
				if ($urandom_range(0, 9) < 7)
					send_request(OP_LOAD, rand_coord(mode), rand_coord(mode),
						1'($urandom_range(0, 1)));
				send_ring(ring_size(), mode, 1);
			end
		end
		s_tvalid <= 1'b0;

		// drain, then allow for the pipeline depth
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
